FILE: sv/inode_block_map_walker_macros.svh
`ifndef INODE_BLOCK_MAP_WALKER_MACROS_SVH
`define INODE_BLOCK_MAP_WALKER_MACROS_SVH

// Concurrent checks clocked on clk and switched off while rst_n is low.
`define IBMW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define IBMW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ibmw_pkg.sv
package ibmw_pkg;

  localparam int DirectSlotsDefault = 6;
  localparam int EntriesPerTable    = 128;
  localparam int BlockBytes         = 512;
  localparam int EntryBytes         = 4;

  localparam int WordW  = 16;
  localparam int AddrW  = 25;
  localparam int EntryW = $clog2(EntriesPerTable);

  localparam logic [WordW-1:0] LimitReset    = 16'd16646;
  localparam logic [WordW-1:0] UnmappedBlock = 16'hFFFF;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MIDDLE,
    PH_FINAL
  } phase_t;

  typedef enum logic [2:0] {
    OP_UNMAPPED,
    OP_DIRECT,
    OP_INDEX_SLOT,
    OP_INDEX_WORD,
    OP_FINAL_WORD
  } op_t;

  function automatic logic [AddrW-1:0] word_address(input logic [WordW-1:0] tbl,
                                                    input logic [EntryW-1:0] entry);
    word_address = AddrW'(tbl) * AddrW'(BlockBytes) + AddrW'(entry) * AddrW'(EntryBytes);
  endfunction

endpackage

FILE: sv/ibmw_slot_ram.sv
module ibmw_slot_ram #(
  parameter int DEPTH = ibmw_pkg::DirectSlotsDefault + 4
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [ibmw_pkg::WordW-1:0]    wr_data,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [ibmw_pkg::WordW-1:0]    rd_data
);

  logic [ibmw_pkg::WordW-1:0] mem [DEPTH];
  logic [ibmw_pkg::WordW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/inode_block_map_walker.sv
// Channel  Direction  Handshake           Beat
// in       input      in_valid/in_stall   command, slot, slot_value, logical_block, read_data
// out      output     out_valid/out_stall kind, read_address, physical_block, unmapped
// cfg      input      cfg_we              cfg_wdata (mapped_limit)
//
// A lookup reads the slot RAM as it enters the s1 stage register, and a returned read word
// is stored there; the result register is then loaded from s1, which frees the input.
// A slot load writes the slot RAM and gives no result. Reset is synchronous and active low;
// it idles the walk and restores mapped_limit, while the slot RAM keeps its contents.
// The input stalls while a beat is in work or while a result waits under out_stall.
module inode_block_map_walker #(
  parameter int DIRECT_SLOTS = ibmw_pkg::DirectSlotsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ibmw_pkg::WordW-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [3:0]                    in_slot,
  input  logic [ibmw_pkg::WordW-1:0]    in_slot_value,
  input  logic [ibmw_pkg::WordW-1:0]    in_logical_block,
  input  logic [ibmw_pkg::WordW-1:0]    in_read_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [ibmw_pkg::AddrW-1:0]    out_read_address,
  output logic [ibmw_pkg::WordW-1:0]    out_physical_block,
  output logic                          out_unmapped
);

  localparam int SlotCount = DIRECT_SLOTS + 4;
  localparam int SlotW     = $clog2(SlotCount);
  localparam int TableSpan = ibmw_pkg::EntriesPerTable * ibmw_pkg::EntriesPerTable;
  localparam int SingleEnd = DIRECT_SLOTS + 2 * ibmw_pkg::EntriesPerTable;
  localparam int DoubleEnd = SingleEnd + 2 * TableSpan;

  localparam int WordW  = ibmw_pkg::WordW;
  localparam int AddrW  = ibmw_pkg::AddrW;
  localparam int EntryW = ibmw_pkg::EntryW;

  ibmw_pkg::phase_t   phase_r, phase_nxt;
  logic [EntryW-1:0]  pending_r, pending_nxt;
  logic [WordW-1:0]   mapped_limit_r, mapped_limit_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  ibmw_pkg::op_t      s1_op_r, s1_op_nxt;
  logic [WordW-1:0]   s1_word_r, s1_word_nxt;
  logic [EntryW-1:0]  s1_entry_r, s1_entry_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [AddrW-1:0]   out_read_address_r, out_read_address_nxt;
  logic [WordW-1:0]   out_physical_block_r, out_physical_block_nxt;
  logic               out_unmapped_r, out_unmapped_nxt;

  logic               ram_we;
  logic [SlotW-1:0]   ram_waddr;
  logic [SlotW-1:0]   ram_raddr;
  logic [WordW-1:0]   ram_rdata;

  logic               in_accept;
  logic               lb_unmapped;
  logic [WordW-1:0]   lb_single;
  logic [WordW-1:0]   lb_double;

  assign in_stall  = s1_valid_r | (out_valid_r & out_stall);
  assign in_accept = in_valid & ~in_stall;

  assign lb_single   = in_logical_block - WordW'(DIRECT_SLOTS);
  assign lb_double   = in_logical_block - WordW'(SingleEnd);
  assign lb_unmapped = (in_logical_block >= mapped_limit_r) ||
                       ({1'b0, in_logical_block} >= (WordW + 1)'(DoubleEnd));

  ibmw_slot_ram #(
    .DEPTH (SlotCount)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_slot_value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    phase_nxt        = phase_r;
    pending_nxt      = pending_r;
    mapped_limit_nxt = cfg_we ? cfg_wdata : mapped_limit_r;
    s1_valid_nxt     = 1'b0;
    s1_op_nxt        = s1_op_r;
    s1_word_nxt      = s1_word_r;
    s1_entry_nxt     = s1_entry_r;
    ram_we           = 1'b0;
    ram_waddr        = SlotW'(in_slot);
    ram_raddr        = '0;

    if (in_accept) begin
      case (in_command)
        ibmw_pkg::CMD_LOAD: begin
          ram_we = (32'(in_slot) < SlotCount);
        end
        ibmw_pkg::CMD_LOOKUP: begin
          s1_valid_nxt = 1'b1;
          phase_nxt    = ibmw_pkg::PH_IDLE;
          if (lb_unmapped) begin
            s1_op_nxt = ibmw_pkg::OP_UNMAPPED;
          end else if (in_logical_block < WordW'(DIRECT_SLOTS)) begin
            s1_op_nxt = ibmw_pkg::OP_DIRECT;
            ram_raddr = SlotW'(in_logical_block);
          end else if (in_logical_block < WordW'(SingleEnd)) begin
            s1_op_nxt    = ibmw_pkg::OP_INDEX_SLOT;
            ram_raddr    = SlotW'(32'(DIRECT_SLOTS) + 32'(lb_single / ibmw_pkg::EntriesPerTable));
            s1_entry_nxt = EntryW'(lb_single % ibmw_pkg::EntriesPerTable);
            phase_nxt    = ibmw_pkg::PH_FINAL;
          end else begin
            s1_op_nxt    = ibmw_pkg::OP_INDEX_SLOT;
            ram_raddr    = SlotW'(32'(DIRECT_SLOTS + 2) + 32'(lb_double / TableSpan));
            s1_entry_nxt = EntryW'((lb_double % TableSpan) / ibmw_pkg::EntriesPerTable);
            pending_nxt  = EntryW'(lb_double % ibmw_pkg::EntriesPerTable);
            phase_nxt    = ibmw_pkg::PH_MIDDLE;
          end
        end
        ibmw_pkg::CMD_READ: begin
          case (phase_r)
            ibmw_pkg::PH_MIDDLE: begin
              s1_valid_nxt = 1'b1;
              s1_op_nxt    = ibmw_pkg::OP_INDEX_WORD;
              s1_word_nxt  = in_read_data;
              s1_entry_nxt = pending_r;
              phase_nxt    = ibmw_pkg::PH_FINAL;
            end
            ibmw_pkg::PH_FINAL: begin
              s1_valid_nxt = 1'b1;
              s1_op_nxt    = ibmw_pkg::OP_FINAL_WORD;
              s1_word_nxt  = in_read_data;
              phase_nxt    = ibmw_pkg::PH_IDLE;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt          = out_valid_r;
    out_kind_nxt           = out_kind_r;
    out_read_address_nxt   = out_read_address_r;
    out_physical_block_nxt = out_physical_block_r;
    out_unmapped_nxt       = out_unmapped_r;

    if (s1_valid_r) begin
      out_valid_nxt          = 1'b1;
      out_kind_nxt           = ibmw_pkg::KIND_DONE;
      out_read_address_nxt   = '0;
      out_physical_block_nxt = '0;
      out_unmapped_nxt       = 1'b0;
      case (s1_op_r)
        ibmw_pkg::OP_UNMAPPED: begin
          out_physical_block_nxt = ibmw_pkg::UnmappedBlock;
          out_unmapped_nxt       = 1'b1;
        end
        ibmw_pkg::OP_DIRECT: begin
          out_physical_block_nxt = ram_rdata;
        end
        ibmw_pkg::OP_INDEX_SLOT: begin
          out_kind_nxt         = ibmw_pkg::KIND_REQUEST;
          out_read_address_nxt = ibmw_pkg::word_address(ram_rdata, s1_entry_r);
        end
        ibmw_pkg::OP_INDEX_WORD: begin
          out_kind_nxt         = ibmw_pkg::KIND_REQUEST;
          out_read_address_nxt = ibmw_pkg::word_address(s1_word_r, s1_entry_r);
        end
        ibmw_pkg::OP_FINAL_WORD: begin
          out_physical_block_nxt = s1_word_r;
        end
        default: begin
        end
      endcase
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ibmw_pkg::PH_IDLE;
      pending_r      <= '0;
      mapped_limit_r <= ibmw_pkg::LimitReset;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      pending_r      <= pending_nxt;
      mapped_limit_r <= mapped_limit_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r              <= s1_op_nxt;
    s1_word_r            <= s1_word_nxt;
    s1_entry_r           <= s1_entry_nxt;
    out_kind_r           <= out_kind_nxt;
    out_read_address_r   <= out_read_address_nxt;
    out_physical_block_r <= out_physical_block_nxt;
    out_unmapped_r       <= out_unmapped_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_read_address   = out_read_address_r;
  assign out_physical_block = out_physical_block_r;
  assign out_unmapped       = out_unmapped_r;

endmodule

FILE: sv/ibmw_checker.sv
`include "inode_block_map_walker_macros.svh"

module ibmw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   in_command,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_kind,
  input logic [ibmw_pkg::AddrW-1:0]   out_read_address,
  input logic [ibmw_pkg::WordW-1:0]   out_physical_block,
  input logic                         out_unmapped
);

  // A stalled result beat keeps its valid and its payload.
  `IBMW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_read_address) && $stable(out_physical_block) && $stable(out_unmapped), "stalled result changed")

  // Every accepted lookup is answered once it has passed the s1 stage and the result register.
  `IBMW_ASSERT_IMP(a_lookup_answered, in_valid && !in_stall && in_command == ibmw_pkg::CMD_LOOKUP, ##2 out_valid, "lookup gave no result")

  // A read request carries no block number and no unmapped flag.
  `IBMW_ASSERT_IMP(a_request_clean, out_valid && out_kind == ibmw_pkg::KIND_REQUEST, !out_unmapped && out_physical_block == '0, "read request carries translation fields")

  // An unmapped answer is a finished translation of the all-ones block.
  `IBMW_ASSERT_IMP(a_unmapped_form, out_valid && out_unmapped, out_kind == ibmw_pkg::KIND_DONE && out_physical_block == ibmw_pkg::UnmappedBlock && out_read_address == '0, "malformed unmapped answer")

endmodule

bind inode_block_map_walker ibmw_checker u_ibmw_checker (.*);
